@@ hdl/dda_pkg.sv @@
package dda_pkg;

	// coordinate and fixed-point formats
	localparam int COORD_BITS = 9;
	localparam int FRAC_BITS = 16;
	localparam int POS_BITS = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS = FRAC_BITS + 2;
	localparam int CNT_BITS = COORD_BITS + 1;
	localparam int CHAN_BITS = 8;
	localparam int COLOR_BITS = 3 * CHAN_BITS;

	// divider iteration counter
	localparam int DIV_CNT_BITS = $clog2(POS_BITS);

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// stream data widths, padded to whole bytes
	localparam int S_DATA_RAW = 4 * COORD_BITS + COLOR_BITS;
	localparam int S_TDATA_BITS = ((S_DATA_RAW + 7) / 8) * 8;
	localparam int M_DATA_RAW = 2 * COORD_BITS + COLOR_BITS;
	localparam int M_TDATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

	// lane index of each axis
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// classified item as held in the queue
	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] mag_x;
		logic [COORD_BITS-1:0] mag_y;
		logic                  neg_x;
		logic                  neg_y;
		logic [COORD_BITS-1:0] step;
		logic [COLOR_BITS-1:0] color;
	} item_t;

	typedef struct packed {
		logic                       start;
		logic [1:0][COORD_BITS-1:0] mag;
		logic [COORD_BITS-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic [1:0][POS_BITS-1:0] quo;
		logic [1:0]               rem_nz;
	} div_rsp_t;

endpackage

@@ hdl/dda_front.sv @@
module dda_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// x_start, y_start, x_end, y_end, red_in, green_in, blue_in, zero pad
	input  logic [dda_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
	// op
	input  logic [0:0]                       s_axis_tuser,
	output logic                             push,
	output dda_pkg::item_t                   push_item,
	input  logic                             full
);

	localparam int CB = dda_pkg::COORD_BITS;
	localparam int CH = dda_pkg::CHAN_BITS;

	logic [CB-1:0] x0, y0, x1, y1;
	logic [CB:0]   dx, dy;
	logic [CB-1:0] mag_x, mag_y;
	dda_pkg::item_t item_c;
	dda_pkg::item_t item_s1;
	logic           valid_s1;
	logic           accept;

	// unpack fields
	assign x0 = s_axis_tdata[CB-1:0];
	assign y0 = s_axis_tdata[2*CB-1:CB];
	assign x1 = s_axis_tdata[3*CB-1:2*CB];
	assign y1 = s_axis_tdata[4*CB-1:3*CB];

	// deltas, magnitudes and major-axis length
	always_comb begin
		dx = {1'b0, x1} - {1'b0, x0};
		dy = {1'b0, y1} - {1'b0, y0};
		mag_x = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		mag_y = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		item_c.op = dda_pkg::op_t'(s_axis_tuser[0]);
		item_c.x0 = x0;
		item_c.y0 = y0;
		item_c.mag_x = mag_x;
		item_c.mag_y = mag_y;
		item_c.neg_x = dx[CB];
		item_c.neg_y = dy[CB];
		item_c.step = (mag_x > mag_y) ? mag_x : mag_y;
		item_c.color = {s_axis_tdata[4*CB+CH-1:4*CB],
			s_axis_tdata[4*CB+2*CH-1:4*CB+CH],
			s_axis_tdata[4*CB+3*CH-1:4*CB+2*CH]};
	end

	// one register stage ahead of the queue
	assign push = valid_s1 && !full;
	assign s_axis_tready = !valid_s1 || !full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

@@ hdl/dda_fifo.sv @@
module dda_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dda_pkg::item_t push_item,
	output logic           full,
	output logic           q_valid,
	output dda_pkg::item_t q_item,
	input  logic           pop
);

	localparam int PB = dda_pkg::FIFO_PTR_BITS;
	localparam int NB = dda_pkg::FIFO_CNT_BITS;
	localparam int DEPTH = dda_pkg::FIFO_DEPTH;

	dda_pkg::item_t mem_q [DEPTH];
	logic [PB-1:0]  wr_ptr_q, rd_ptr_q;
	logic [NB-1:0]  cnt_q;

	assign full = (cnt_q == NB'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("queue read while empty");

endmodule

@@ hdl/dda_div.sv @@
module dda_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dda_pkg::div_req_t req,
	output dda_pkg::div_rsp_t rsp
);

	localparam int CB = dda_pkg::COORD_BITS;
	localparam int PB = dda_pkg::POS_BITS;
	localparam int FB = dda_pkg::FRAC_BITS;
	localparam int KB = dda_pkg::DIV_CNT_BITS;

	logic          busy_q;
	logic          done_q;
	logic [KB-1:0] cnt_q;
	logic [CB-1:0] divisor_q;
	logic [CB-1:0] rem_q [2];
	logic [PB-1:0] nq_q [2];
	logic [CB:0]   rem_sh [2];
	logic          ge [2];
	logic [CB-1:0] rem_nx [2];

	// one restoring step per lane; the dividend shifts out, quotient bits shift in
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem_sh[i] = {rem_q[i], nq_q[i][PB-1]};
			ge[i] = (rem_sh[i] >= {1'b0, divisor_q});
			rem_nx[i] = ge[i] ? CB'(rem_sh[i] - {1'b0, divisor_q}) : rem_sh[i][CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= KB'(PB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= '0;
				nq_q[i] <= {req.mag[i], {FB{1'b0}}};
			end
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= rem_nx[i];
				nq_q[i] <= {nq_q[i][PB-2:0], ge[i]};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		for (int i = 0; i < 2; i++) begin
			rsp.quo[i] = nq_q[i];
			rsp.rem_nz[i] = (rem_q[i] != '0);
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");

endmodule

@@ hdl/dda_back.sv @@
module dda_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  dda_pkg::item_t                   q_item,
	output logic                             q_pop,
	output dda_pkg::div_req_t                div_req,
	input  dda_pkg::div_rsp_t                div_rsp,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero pad
	output logic [dda_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	output logic                             m_axis_tlast
);

	localparam int CB = dda_pkg::COORD_BITS;
	localparam int FB = dda_pkg::FRAC_BITS;
	localparam int PB = dda_pkg::POS_BITS;
	localparam int IB = dda_pkg::INC_BITS;
	localparam int NB = dda_pkg::CNT_BITS;
	localparam int CH = dda_pkg::CHAN_BITS;
	localparam int LB = dda_pkg::COLOR_BITS;

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} state_t;

	state_t        state_q;
	logic [PB-1:0] pos_q [2];
	logic [IB-1:0] inc_q [2];
	logic [IB-1:0] inc_nx [2];
	logic [IB-1:0] quo_t [2];
	logic          neg_q [2];
	logic [NB-1:0] left_q;
	logic [LB-1:0] color_q;
	logic          out_valid_q;
	logic [CB-1:0] out_x_q, out_y_q;
	logic [LB-1:0] out_color_q;
	logic          out_last_q;
	logic          is_load, active, can_emit, emit, zero_len;

	// dispatch from the queue
	always_comb begin
		is_load = (q_item.op == dda_pkg::OP_LOAD);
		zero_len = (q_item.step == '0);
		active = (left_q != '0);
		can_emit = !out_valid_q || m_axis_tready;
		q_pop = 1'b0;
		emit = 1'b0;
		if (state_q == ST_RUN && q_valid) begin
			if (is_load || !active) begin
				q_pop = 1'b1;
			end else if (can_emit) begin
				q_pop = 1'b1;
				emit = 1'b1;
			end
		end
		div_req.start = q_pop && is_load && !zero_len;
		div_req.mag[dda_pkg::AXIS_X] = q_item.mag_x;
		div_req.mag[dda_pkg::AXIS_Y] = q_item.mag_y;
		div_req.divisor = q_item.step;
	end

	// increments: rounded up for a rising axis, negated quotient for a falling one
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			quo_t[i] = div_rsp.quo[i][IB-1:0];
			inc_nx[i] = neg_q[i] ? IB'(-quo_t[i]) : IB'(quo_t[i] + IB'(div_rsp.rem_nz[i]));
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (div_req.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			if (q_pop && is_load) begin
				left_q <= NB'({1'b0, q_item.step}) + 1'b1;
			end else if (emit) begin
				left_q <= left_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line state and output register
	always_ff @(posedge clk) begin
		if (q_pop && is_load) begin
			pos_q[dda_pkg::AXIS_X] <= {q_item.x0, {FB{1'b0}}};
			pos_q[dda_pkg::AXIS_Y] <= {q_item.y0, {FB{1'b0}}};
			neg_q[dda_pkg::AXIS_X] <= q_item.neg_x;
			neg_q[dda_pkg::AXIS_Y] <= q_item.neg_y;
			color_q <= q_item.color;
			if (zero_len) begin
				inc_q[dda_pkg::AXIS_X] <= '0;
				inc_q[dda_pkg::AXIS_Y] <= '0;
			end
		end else if (emit) begin
			for (int i = 0; i < 2; i++) begin
				pos_q[i] <= pos_q[i] + {{(PB-IB){inc_q[i][IB-1]}}, inc_q[i]};
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			inc_q[dda_pkg::AXIS_X] <= inc_nx[dda_pkg::AXIS_X];
			inc_q[dda_pkg::AXIS_Y] <= inc_nx[dda_pkg::AXIS_Y];
		end
		if (emit) begin
			out_x_q <= pos_q[dda_pkg::AXIS_X][PB-1:FB];
			out_y_q <= pos_q[dda_pkg::AXIS_Y][PB-1:FB];
			out_color_q <= color_q;
			out_last_q <= (left_q == NB'(1));
		end
	end

	// color is held red high, blue low; the stream carries red first
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = dda_pkg::M_TDATA_BITS'({out_color_q[CH-1:0],
		out_color_q[2*CH-1:CH], out_color_q[3*CH-1:2*CH], out_y_q, out_x_q});

	a_no_pop_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !q_pop) else $error("queue read during divide");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV)) else $error("divide done out of turn");
	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (left_q == $past(left_q) - 1'b1)) else $error("pixel count slip");

endmodule

@@ hdl/dda_line_rasterizer.sv @@
// Channel   Direction  tdata                                      tuser  tlast
// s_axis    in         x_start,y_start,x_end,y_end,red,green,blue op     -
// m_axis    out        pixel_x,pixel_y,red,green,blue             -      last_pixel
//
// Advance transfers yield one pixel per cycle while a line has pixels left,
// no divide is running and the output is taken. A load of a non-zero line
// waits in the divide state while the shared bit-serial divider forms both axis increments.
// A two-entry queue parts input classification from pixel stepping; input
// transfers continue in a divide or output stall till queue and input stage fill.
// arst_n clears the queue, the pixel count and the output register.
module dda_line_rasterizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// x_start, y_start, x_end, y_end, red_in, green_in, blue_in, zero pad
	input  logic [dda_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
	// op
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero pad
	output logic [dda_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
	// last_pixel
	output logic                             m_axis_tlast
);

	logic              push, full, q_valid, q_pop;
	dda_pkg::item_t    push_item, q_item;
	dda_pkg::div_req_t div_req;
	dda_pkg::div_rsp_t div_rsp;

	dda_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	dda_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (q_pop)
	);

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dda_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = dda_pkg::COORD_BITS;
	localparam int FRAC_BITS = dda_pkg::FRAC_BITS;
	localparam int POS_BITS = dda_pkg::POS_BITS;
	localparam int INC_BITS = dda_pkg::INC_BITS;
	localparam int CNT_BITS = dda_pkg::CNT_BITS;
	localparam int CHAN_BITS = dda_pkg::CHAN_BITS;
	localparam int S_DATA_RAW = dda_pkg::S_DATA_RAW;
	localparam int S_TDATA_BITS = dda_pkg::S_TDATA_BITS;
	localparam int M_TDATA_BITS = dda_pkg::M_TDATA_BITS;

	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_CHOKE
	} rx_mode_t;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [CHAN_BITS-1:0]  red;
		logic [CHAN_BITS-1:0]  green;
		logic [CHAN_BITS-1:0]  blue;
		logic                  last;
	} pixel_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// x_start, y_start, x_end, y_end, red_in, green_in, blue_in, zero pad
	logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
	// op
	logic [0:0]              s_axis_tuser = dda_pkg::OP_LOAD;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero pad
	logic [M_TDATA_BITS-1:0] m_axis_tdata;
	logic                    m_axis_tlast;

	// line state mirrored by the predictor
	logic [POS_BITS-1:0]          trace_x, trace_y;
	logic signed [INC_BITS-1:0]   slope_x, slope_y;
	logic [CNT_BITS-1:0]          pixels_due;
	logic                         drawing;
	logic [CHAN_BITS-1:0]         ink_red, ink_green, ink_blue;

	pixel_t expected_pixels[$];
	int     mismatches = 0;
	int     items_counted = 0;
	int     burst_left = 0;
	int     quiet_cycles = 0;

	rx_mode_t ready_mode = RX_OPEN;
	int       pattern_left = 0;

	dda_line_rasterizer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ceil(delta * 2^F / run), exact when the division is exact
	function automatic logic signed [INC_BITS-1:0] axis_slope(int delta, int run);
		if (run == 0)
			return '0;
		if (delta >= 0)
			return INC_BITS'(((delta << FRAC_BITS) + run - 1) / run);
		return INC_BITS'(-(((-delta) << FRAC_BITS) / run));
	endfunction

	// advance the mirrored line by one transfer; returns 1 when a pixel is due
	function automatic bit rasterize_step(dda_pkg::op_t op, logic [COORD_BITS-1:0] xs,
			logic [COORD_BITS-1:0] ys, logic [COORD_BITS-1:0] xe,
			logic [COORD_BITS-1:0] ye, logic [CHAN_BITS-1:0] r,
			logic [CHAN_BITS-1:0] g, logic [CHAN_BITS-1:0] b);
		int     dx, dy, run;
		pixel_t px;
		if (op == dda_pkg::OP_LOAD) begin
			dx = int'(xe) - int'(xs);
			dy = int'(ye) - int'(ys);
			run = (dx < 0) ? -dx : dx;
			if ((dy < 0 ? -dy : dy) > run)
				run = (dy < 0) ? -dy : dy;
			slope_x = axis_slope(dx, run);
			slope_y = axis_slope(dy, run);
			trace_x = {xs, {FRAC_BITS{1'b0}}};
			trace_y = {ys, {FRAC_BITS{1'b0}}};
			pixels_due = CNT_BITS'(run + 1);
			drawing = 1'b1;
			ink_red = r;
			ink_green = g;
			ink_blue = b;
			return 1'b0;
		end
		// advance while idle leaves everything alone
		if (!drawing || pixels_due == 0) begin
			drawing = 1'b0;
			return 1'b0;
		end
		px.x = trace_x[POS_BITS-1:FRAC_BITS];
		px.y = trace_y[POS_BITS-1:FRAC_BITS];
		px.red = ink_red;
		px.green = ink_green;
		px.blue = ink_blue;
		px.last = (pixels_due == 1);
		expected_pixels.insert(expected_pixels.size(), px);
		trace_x = trace_x + {{(POS_BITS-INC_BITS){slope_x[INC_BITS-1]}}, slope_x};
		trace_y = trace_y + {{(POS_BITS-INC_BITS){slope_y[INC_BITS-1]}}, slope_y};
		pixels_due = pixels_due - 1'b1;
		if (pixels_due == 0)
			drawing = 1'b0;
		return 1'b1;
	endfunction

	// one input transfer, with bursts and random gaps on the sender side
	task automatic send_item(dda_pkg::op_t op, logic [COORD_BITS-1:0] xs,
			logic [COORD_BITS-1:0] ys,
			logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye,
			logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g, logic [CHAN_BITS-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(S_TDATA_BITS-S_DATA_RAW){1'b0}}, b, g, r, ye, xe, ys, xs};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (rasterize_step(op, xs, ys, xe, ye, r, g, b) || op == dda_pkg::OP_LOAD)
			items_counted++;
	endtask

	task automatic load_line(int xs, int ys, int xe, int ye,
			logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g, logic [CHAN_BITS-1:0] b);
		send_item(dda_pkg::OP_LOAD, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
			COORD_BITS'(ye), r, g, b);
	endtask

	// advance data fields carry noise; the block must ignore them
	task automatic advance_pixels(int count);
		repeat (count)
			send_item(dda_pkg::OP_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
				COORD_BITS'($urandom), COORD_BITS'($urandom),
				CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom));
	endtask

	function automatic int mirror_end(int origin, int delta);
		int e;
		e = origin + delta;
		if (e < 0 || e > COORD_MAX)
			e = origin - delta;
		return e;
	endfunction

	task automatic test_idle_advance;
		advance_pixels(1);
	endtask

	task automatic test_zero_length;
		load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF);
		advance_pixels(2);
	endtask

	task automatic test_shallow_line;
		load_line(0, 0, 3, 1, 8'h00, 8'h00, 8'h00);
		advance_pixels(4);
	endtask

	// steep line falling backward, cut off by a short horizontal one
	task automatic test_reload_midline;
		load_line(5, 9, 2, 0, 8'hA5, 8'h5A, 8'h0F);
		advance_pixels(3);
		load_line(10, 10, 8, 10, 8'h3C, 8'hC3, 8'h81);
		advance_pixels(3);
	endtask

	// full-span diagonals; the random part abandons the last one
	task automatic test_corner_lines;
		load_line(COORD_MAX, 0, 0, COORD_MAX, 8'h01, 8'h80, 8'hFE);
		advance_pixels(2);
		load_line(0, COORD_MAX, COORD_MAX, 0, 8'h7F, 8'hFE, 8'h01);
		advance_pixels(2);
		load_line(0, 0, COORD_MAX, COORD_MAX, 8'hFF, 8'h00, 8'hAA);
		advance_pixels(1);
	endtask

	// mostly complete short lines; some cut short, some overrun into idle
	task automatic test_random_lines(int quota);
		int first, kind, span, xs, ys, xe, ye, count, tail;
		first = items_counted;
		while (items_counted - first < quota) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				advance_pixels($urandom_range(1, 3));
			end else begin
				xs = $urandom_range(0, COORD_MAX);
				ys = $urandom_range(0, COORD_MAX);
				if (kind < 8) begin
					xe = $urandom_range(0, COORD_MAX);
					ye = $urandom_range(0, COORD_MAX);
				end else if (kind < 11) begin
					xe = xs;
					ye = ys;
				end else begin
					span = (kind < 21) ? 64 : 12;
					xe = mirror_end(xs, $urandom_range(0, 2 * span) - span);
					ye = mirror_end(ys, $urandom_range(0, 2 * span) - span);
				end
				load_line(xs, ys, xe, ye, CHAN_BITS'($urandom), CHAN_BITS'($urandom),
					CHAN_BITS'($urandom));
				count = int'(pixels_due);
				tail = $urandom_range(0, 99);
				if (tail < 15)
					count = $urandom_range(0, count - 1);
				else if (tail < 30)
					count = count + $urandom_range(1, 3);
				advance_pixels(count);
			end
		end
	endtask

	// hold the sender until every pixel is out, then let the block settle
	task automatic test_drain_pause;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// output stall pattern, switched at random intervals
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			pattern_left <= $urandom_range(8, 60);
			ready_mode <= rx_mode_t'($urandom_range(0, 3));
		end else begin
			pattern_left <= pattern_left - 1;
		end
		case (ready_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (pattern_left < 3);
		endcase
	end

	task automatic check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// compare each output transfer against the oldest predicted pixel
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual tdata %h tlast %b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_x", want.x, m_axis_tdata[0 +: COORD_BITS]);
				check_field("pixel_y", want.y, m_axis_tdata[COORD_BITS +: COORD_BITS]);
				check_field("pixel_red", want.red, m_axis_tdata[2*COORD_BITS +: CHAN_BITS]);
				check_field("pixel_green", want.green,
					m_axis_tdata[2*COORD_BITS+CHAN_BITS +: CHAN_BITS]);
				check_field("pixel_blue", want.blue,
					m_axis_tdata[2*COORD_BITS+2*CHAN_BITS +: CHAN_BITS]);
				check_field("last_pixel", want.last, m_axis_tlast);
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		trace_x = '0;
		trace_y = '0;
		slope_x = '0;
		slope_y = '0;
		pixels_due = '0;
		drawing = 1'b0;
		ink_red = '0;
		ink_green = '0;
		ink_blue = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_advance();
		test_zero_length();
		test_shallow_line();
		test_reload_midline();
		test_corner_lines();
		test_random_lines(360);
		test_drain_pause();
		test_random_lines(360);

		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ dda_line_rasterizer.f @@
hdl/dda_pkg.sv
hdl/dda_front.sv
hdl/dda_fifo.sv
hdl/dda_div.sv
hdl/dda_back.sv
hdl/dda_line_rasterizer.sv
verif/tb.sv
